// ----- rtl/core/fba_pkg.sv -----
// Shared constants and types of the fader block averager.
`default_nettype none

package fba_pkg;

  localparam int SAMPLE_W = 12;
  localparam int PCT_W = 7;
  localparam int MAX_CH = 4;

  localparam int DEF_SAMPLES_PER_BLOCK = 16;
  localparam int DEF_CHANNELS = 4;

  // Division by 41 as a multiply by 3197 and a shift by 17; exact below 26214.
  localparam int PCT_RECIP_W = 12;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 12'd3197;
  localparam int PCT_SHIFT = 17;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en_out;
    logic commit;
  } pipe_en_t;

endpackage

`default_nettype wire

// ----- rtl/core/fba_avg_pct.sv -----
// Per-channel pipeline from a block sum to its average, percent and change bit.
`default_nettype none

module fba_avg_pct #(
  parameter int SAMPLES_PER_BLOCK = fba_pkg::DEF_SAMPLES_PER_BLOCK,
  parameter int SUM_W = fba_pkg::SAMPLE_W + $clog2(fba_pkg::DEF_SAMPLES_PER_BLOCK)
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  fba_pkg::pipe_en_t                en_i,
  input  wire  [SUM_W-1:0]                 sum_i,
  output logic [fba_pkg::SAMPLE_W-1:0]     avg_o,
  output logic [fba_pkg::PCT_W-1:0]        pct_o,
  output logic                             diff_o
);

  localparam int SW = fba_pkg::SAMPLE_W;
  localparam int PW = fba_pkg::PCT_W;
  localparam int PROD_W = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'((64'd1 << SUM_W) / SAMPLES_PER_BLOCK);
  localparam logic [SUM_W-1:0] BLOCK = SUM_W'(SAMPLES_PER_BLOCK);
  localparam int PPROD_W = SW + fba_pkg::PCT_RECIP_W;

  logic [SUM_W-1:0] s1_sum_q;
  logic [SUM_W-1:0] s2_sum_q;
  logic [SW-1:0]    s2_qest_q;
  logic [SW-1:0]    s3_avg_q;
  logic [SW-1:0]    avg_q;
  logic [PW-1:0]    pct_q;
  logic             diff_q;
  logic [PW-1:0]    prev_q;

  logic [PROD_W-1:0]  qprod;
  logic [SW-1:0]      qest_d;
  logic [SUM_W-1:0]   back;
  logic [SUM_W-1:0]   rem;
  logic [SW-1:0]      avg_d;
  logic [PPROD_W-1:0] pprod;
  logic [PW-1:0]      pct_d;

  assign qprod  = PROD_W'(s1_sum_q) * PROD_W'(RECIP);
  assign qest_d = qprod[SUM_W +: SW];

  assign back  = SUM_W'(SUM_W'(s2_qest_q) * BLOCK);
  assign rem   = s2_sum_q - back;
  assign avg_d = s2_qest_q + SW'(rem >= BLOCK);

  assign pprod = PPROD_W'(s3_avg_q) * PPROD_W'(fba_pkg::PCT_RECIP);
  assign pct_d = pprod[fba_pkg::PCT_SHIFT +: PW];

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      s1_sum_q <= sum_i;
    end
    if (en_i.en2) begin
      s2_sum_q  <= s1_sum_q;
      s2_qest_q <= qest_d;
    end
    if (en_i.en3) begin
      s3_avg_q <= avg_d;
    end
    if (en_i.en_out) begin
      avg_q  <= s3_avg_q;
      pct_q  <= pct_d;
      diff_q <= (pct_d != prev_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (en_i.commit) begin
      prev_q <= pct_d;
    end
  end

  assign avg_o  = avg_q;
  assign pct_o  = pct_q;
  assign diff_o = diff_q;

endmodule

`default_nettype wire

// ----- rtl/core/fader_block_averager.sv -----
// Top level: four-channel fader block averager with percent output and change flag.
// Throughput is one scan request per cycle while in_ready_o is high; the accumulators add
// only accepted scans. The result of a block passes in order through the sum capture, the
// reciprocal multiply, its correction and the percent multiply registers before it is valid.
// Reset clears the accumulators, the scan counter, the stored percents and all valid bits.
`default_nettype none

module fader_block_averager #(
  parameter int SAMPLES_PER_BLOCK = fba_pkg::DEF_SAMPLES_PER_BLOCK,
  parameter int CHANNELS = fba_pkg::DEF_CHANNELS
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [fba_pkg::SAMPLE_W-1:0]     sample_ch0_i,
  input  wire  [fba_pkg::SAMPLE_W-1:0]     sample_ch1_i,
  input  wire  [fba_pkg::SAMPLE_W-1:0]     sample_ch2_i,
  input  wire  [fba_pkg::SAMPLE_W-1:0]     sample_ch3_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [fba_pkg::SAMPLE_W-1:0]     average_ch0_o,
  output logic [fba_pkg::SAMPLE_W-1:0]     average_ch1_o,
  output logic [fba_pkg::SAMPLE_W-1:0]     average_ch2_o,
  output logic [fba_pkg::SAMPLE_W-1:0]     average_ch3_o,
  output logic [fba_pkg::PCT_W-1:0]        percent_ch0_o,
  output logic [fba_pkg::PCT_W-1:0]        percent_ch1_o,
  output logic [fba_pkg::PCT_W-1:0]        percent_ch2_o,
  output logic [fba_pkg::PCT_W-1:0]        percent_ch3_o,
  output logic                             settings_changed_o
);

  localparam int SW = fba_pkg::SAMPLE_W;
  localparam int NCH = fba_pkg::MAX_CH;
  localparam int SUM_W = SW + $clog2(SAMPLES_PER_BLOCK);
  localparam int CNT_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_BLOCK - 1);

  logic [SW-1:0]    sample_in [NCH];
  logic [SW-1:0]    sample_act [NCH];
  logic [SUM_W-1:0] acc_q [NCH];
  logic [SUM_W-1:0] acc_sum [NCH];
  logic [SW-1:0]    avg [NCH];
  logic [fba_pkg::PCT_W-1:0] pct [NCH];
  logic [NCH-1:0]   diff;

  logic [CNT_W-1:0] cnt_q;
  logic             v1_q, v2_q, v3_q, vout_q;
  logic             accept, last;
  fba_pkg::pipe_en_t en;

  assign sample_in[0] = sample_ch0_i;
  assign sample_in[1] = sample_ch1_i;
  assign sample_in[2] = sample_ch2_i;
  assign sample_in[3] = sample_ch3_i;

  always_comb begin
    en.en_out = !vout_q || out_ready_i;
    en.en3    = !v3_q || en.en_out;
    en.en2    = !v2_q || en.en3;
    en.en1    = !v1_q || en.en2;
    en.commit = en.en_out && v3_q;
  end

  assign in_ready_o = en.en1;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (cnt_q == LAST_CNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= last ? '0 : cnt_q + CNT_W'(1);
      end
      if (en.en1) begin
        v1_q <= accept && last;
      end
      if (en.en2) begin
        v2_q <= v1_q;
      end
      if (en.en3) begin
        v3_q <= v2_q;
      end
      if (en.en_out) begin
        vout_q <= v3_q;
      end
    end
  end

  for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
    assign sample_act[ch] = (ch < CHANNELS) ? sample_in[ch] : '0;
    assign acc_sum[ch]    = acc_q[ch] + SUM_W'(sample_act[ch]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q[ch] <= '0;
      end else if (accept) begin
        acc_q[ch] <= last ? '0 : acc_sum[ch];
      end
    end

    fba_avg_pct #(
      .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
      .SUM_W             (SUM_W)
    ) u_avg_pct (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .sum_i  (acc_sum[ch]),
      .avg_o  (avg[ch]),
      .pct_o  (pct[ch]),
      .diff_o (diff[ch])
    );
  end

  assign out_valid_o        = vout_q;
  assign average_ch0_o      = avg[0];
  assign average_ch1_o      = avg[1];
  assign average_ch2_o      = avg[2];
  assign average_ch3_o      = avg[3];
  assign percent_ch0_o      = pct[0];
  assign percent_ch1_o      = pct[1];
  assign percent_ch2_o      = pct[2];
  assign percent_ch3_o      = pct[3];
  assign settings_changed_o = |diff;

endmodule

`default_nettype wire
